[sv/bur_pkg.sv]
// Shared types, codes and the CRC-32 byte update for the block upload receiver.
package bur_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ALL  = 32'hFFFFFFFF;

	localparam logic [7:0] NACK_OFFSET  = 8'h02;
	localparam logic [7:0] NACK_PARAM   = 8'h03;
	localparam logic [7:0] NACK_STORAGE = 8'h04;
	localparam logic [7:0] NACK_VERIFY  = 8'h05;

	localparam logic [3:0] REG_TOTAL_LENGTH = 4'h0;
	localparam logic [3:0] REG_EXPECTED_CRC = 4'h4;
	localparam logic [3:0] REG_HANDLE       = 4'h8;
	localparam logic [3:0] REG_BASE_ADDRESS = 4'hC;

	typedef enum logic [2:0] {
		MODE_START   = 3'd0,
		MODE_BEGIN   = 3'd1,
		MODE_HABORT  = 3'd2,
		MODE_HEADER  = 3'd3,
		MODE_BYTE    = 3'd4,
		MODE_END     = 3'd5,
		MODE_LABORT  = 3'd6,
		MODE_UNUSED  = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_RECEIVING = 3'd1,
		PH_COMPLETED = 3'd2,
		PH_ABORTED   = 3'd3,
		PH_ERROR     = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ERR_OK      = 3'd0,
		ERR_PARAM   = 3'd1,
		ERR_BUSY    = 3'd2,
		ERR_OFFSET  = 3'd3,
		ERR_STORAGE = 3'd4,
		ERR_VERIFY  = 3'd5
	} err_t;

	typedef enum logic [1:0] {
		RK_NONE  = 2'd0,
		RK_ACK   = 2'd1,
		RK_NACK  = 2'd2,
		RK_ABORT = 2'd3
	} reply_t;

	// One classified item as it waits between the front and the back.
	typedef struct packed {
		mode_t       mode;
		logic        hnd_match;
		logic        fits;
		logic        start_bad;
		logic [31:0] offset;
		logic [15:0] pay_len;
		logic [7:0]  data_byte;
		logic        data_last;
		logic        storage_ok;
		logic [31:0] end_crc;
		logic [7:0]  abort_reason;
	} entry_t;

	typedef struct packed {
		logic        consumed;
		reply_t      reply_kind;
		logic [7:0]  reply_code;
		logic [31:0] reply_offset;
		logic [15:0] reply_length;
		logic        write_valid;
		logic [31:0] write_address;
		logic [7:0]  write_byte;
		phase_t      session_state;
		err_t        err_status;
		logic [31:0] running_crc;
	} result_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ CRC_ALL ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c ^ CRC_ALL;
	endfunction

endpackage

[sv/bur_front.sv]
// Front part: unpacks an accepted item and precomputes its session checks.
module bur_front (
	input  logic [2:0]            mode,
	input  logic [111:0]          payload,
	input  logic                  last,
	input  logic [31:0]           total_length,
	input  logic [7:0]            session_handle,
	output bur_pkg::entry_t       entry
);
	import bur_pkg::*;

	logic [32:0] chunk_end;

	assign chunk_end = {1'b0, payload[39:8]} + {17'd0, payload[55:40]};

	always_comb begin
		entry.mode         = mode_t'(mode);
		entry.hnd_match    = (payload[7:0] == session_handle);
		entry.fits         = (chunk_end <= {1'b0, total_length});
		entry.start_bad    = (total_length == 32'd0) || (session_handle == 8'd0);
		entry.offset       = payload[39:8];
		entry.pay_len      = payload[55:40];
		entry.data_byte    = payload[63:56];
		entry.data_last    = last;
		entry.storage_ok   = payload[64];
		entry.end_crc      = payload[96:65];
		entry.abort_reason = payload[104:97];
	end
endmodule

[sv/bur_queue.sv]
// Two-entry queue that decouples the front from the back.
module bur_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bur_pkg::entry_t push_data,
	input  logic            pop,
	output bur_pkg::entry_t pop_data,
	output logic            full,
	output logic            not_empty
);
	import bur_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

[sv/bur_back.sv]
// Back part: session state machine, CRC, storage writes and the result register.
module bur_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  bur_pkg::entry_t item,
	input  logic [31:0]     total_length,
	input  logic [31:0]     expected_crc,
	input  logic [31:0]     base_address,
	output bur_pkg::result_t result_q
);
	import bur_pkg::*;

	phase_t      phase_q, phase_d;
	err_t        err_q, err_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] next_off_q, next_off_d;
	logic        open_q, open_d;
	logic [31:0] cstart_q, cstart_d;
	logic [15:0] csize_q, csize_d;
	logic [15:0] ccount_q, ccount_d;
	logic [15:0] count_inc;
	logic [31:0] crc_new;
	logic        host_ok;
	result_t     res;

	assign host_ok   = (phase_q == PH_RECEIVING) && item.hnd_match;
	assign count_inc = ccount_q + 16'd1;
	assign crc_new   = crc_byte(crc_q, item.data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			err_q      <= ERR_OK;
			crc_q      <= '0;
			next_off_q <= '0;
			open_q     <= 1'b0;
			cstart_q   <= '0;
			csize_q    <= '0;
			ccount_q   <= '0;
		end else if (take) begin
			phase_q    <= phase_d;
			err_q      <= err_d;
			crc_q      <= crc_d;
			next_off_q <= next_off_d;
			open_q     <= open_d;
			cstart_q   <= cstart_d;
			csize_q    <= csize_d;
			ccount_q   <= ccount_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) result_q <= res;
	end

	always_comb begin
		phase_d    = phase_q;
		err_d      = err_q;
		crc_d      = crc_q;
		next_off_d = next_off_q;
		open_d     = open_q;
		cstart_d   = cstart_q;
		csize_d    = csize_q;
		ccount_d   = ccount_q;
		res        = '0;
		unique case (item.mode)
			MODE_START: begin
				open_d = 1'b0;
				if (item.start_bad) begin
					err_d = ERR_PARAM; phase_d = PH_ERROR;
				end else if (phase_q == PH_RECEIVING) begin
					err_d = ERR_BUSY; phase_d = PH_ERROR;
				end else if (!item.storage_ok) begin
					err_d = ERR_STORAGE; phase_d = PH_ERROR;
				end else begin
					phase_d = PH_RECEIVING; next_off_d = '0; crc_d = '0; err_d = ERR_OK;
					cstart_d = '0; csize_d = '0; ccount_d = '0;
				end
			end
			MODE_BEGIN: begin
				if (host_ok) begin
					res.consumed = 1'b1; res.reply_kind = RK_ACK;
					res.reply_length = item.pay_len;
				end
			end
			MODE_HABORT: begin
				if (host_ok) begin
					res.consumed = 1'b1; phase_d = PH_ABORTED; err_d = ERR_OK; open_d = 1'b0;
					res.reply_kind = RK_ACK; res.reply_offset = item.offset;
					res.reply_length = item.pay_len;
				end
			end
			MODE_HEADER: begin
				if (host_ok) begin
					res.consumed = 1'b1; open_d = 1'b0;
					res.reply_offset = item.offset;
					if (item.offset != next_off_q) begin
						res.reply_kind = RK_NACK; res.reply_code = NACK_OFFSET;
						err_d = ERR_OFFSET; phase_d = PH_ERROR;
					end else if (!item.fits) begin
						res.reply_kind = RK_NACK; res.reply_code = NACK_PARAM;
						err_d = ERR_PARAM; phase_d = PH_ERROR;
					end else if (!item.storage_ok) begin
						res.reply_kind = RK_NACK; res.reply_code = NACK_STORAGE;
						err_d = ERR_STORAGE; phase_d = PH_ERROR;
					end else if (item.pay_len == 16'd0) begin
						res.reply_kind = RK_ACK;
					end else begin
						res.reply_offset = '0;
						open_d = 1'b1; cstart_d = item.offset;
						csize_d = item.pay_len; ccount_d = '0;
					end
				end
			end
			MODE_BYTE: begin
				if (phase_q == PH_RECEIVING && open_q) begin
					res.consumed = 1'b1; res.write_valid = 1'b1;
					res.write_byte = item.data_byte;
					// next_offset tracks chunk_start plus the bytes taken so far.
					res.write_address = base_address + next_off_q;
					crc_d = crc_new;
					next_off_d = next_off_q + 32'd1;
					ccount_d = count_inc;
					if (count_inc >= csize_q || item.data_last) begin
						open_d = 1'b0; res.reply_kind = RK_ACK;
						res.reply_offset = cstart_q; res.reply_length = count_inc;
					end
				end
			end
			MODE_END: begin
				if (host_ok) begin
					res.consumed = 1'b1; open_d = 1'b0;
					res.reply_offset = item.offset;
					if (next_off_q != total_length ||
					    (expected_crc != 32'd0 && crc_q != expected_crc) ||
					    (item.end_crc != 32'd0 && item.end_crc != crc_q)) begin
						res.reply_kind = RK_NACK; res.reply_code = NACK_VERIFY;
						err_d = ERR_VERIFY; phase_d = PH_ERROR;
					end else begin
						phase_d = PH_COMPLETED; err_d = ERR_OK;
						res.reply_kind = RK_ACK; res.reply_length = item.pay_len;
					end
				end
			end
			MODE_LABORT: begin
				if (phase_q == PH_RECEIVING) begin
					res.reply_kind = RK_ABORT; res.reply_code = item.abort_reason;
				end
				phase_d = PH_ABORTED; err_d = ERR_OK; open_d = 1'b0;
			end
			default: begin
			end
		endcase
		res.session_state = phase_d;
		res.err_status    = err_d;
		res.running_crc   = crc_d;
	end
endmodule

[sv/block_upload_receiver.sv]
// Top level of the block upload receiver: ports, register file and the front/queue/back chain.
// An accepted item waits in the queue until the back takes it into the result register.
// Throughput: one item per cycle while the result stream is ready; the back executes one item
// per cycle against a two-entry queue. The result register stalls only the back; the queue lets
// the input side keep going meanwhile until the queue is full.
// Reset (arst_n low, asynchronous): session idle, CRC and counters zero, registers zero, no result.
module block_upload_receiver (
	input  logic         clk,
	input  logic         arst_n,
	// Input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata from bit 0: handle, offset, pay_len, data_byte, storage_ok, end_crc,
	// abort_reason, zero fill
	input  logic [111:0] s_tdata,
	input  logic [2:0]   s_tuser,   // mode
	input  logic         s_tlast,   // data_last
	// Result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata from bit 0: consumed, reply_code, reply_offset, reply_length, write_valid,
	// write_address, write_byte, session_state, err_status, running_crc
	output logic [135:0] m_tdata,
	output logic [1:0]   m_tuser,   // reply_kind
	// Configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import bur_pkg::*;

	logic [31:0] total_length_q;
	logic [31:0] expected_crc_q;
	logic [7:0]  session_handle_q;
	logic [31:0] base_address_q;
	logic        cfg_write;

	entry_t      front_entry;
	entry_t      back_entry;
	logic        q_full;
	logic        q_not_empty;
	logic        push;
	logic        take;
	logic        out_valid_q;
	result_t     result_q;

	// Register file. Writes complete on the access cycle; pready never stalls.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_length_q   <= '0;
			expected_crc_q   <= '0;
			session_handle_q <= '0;
			base_address_q   <= '0;
		end else if (cfg_write) begin
			unique case (paddr)
				REG_TOTAL_LENGTH: total_length_q   <= pwdata;
				REG_EXPECTED_CRC: expected_crc_q   <= pwdata;
				REG_HANDLE:       session_handle_q <= pwdata[7:0];
				REG_BASE_ADDRESS: base_address_q   <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			REG_TOTAL_LENGTH: prdata = total_length_q;
			REG_EXPECTED_CRC: prdata = expected_crc_q;
			REG_HANDLE:       prdata = {24'd0, session_handle_q};
			REG_BASE_ADDRESS: prdata = base_address_q;
			default:          prdata = '0;
		endcase
	end

	// Front: every item is classified as it arrives and goes into the queue.
	bur_front u_front (
		.mode           (s_tuser),
		.payload        (s_tdata),
		.last           (s_tlast),
		.total_length   (total_length_q),
		.session_handle (session_handle_q),
		.entry          (front_entry)
	);

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	bur_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_entry),
		.pop       (take),
		.pop_data  (back_entry),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	// The back takes the queue head whenever the result register is free or
	// being emptied in the same cycle.
	assign take = q_not_empty && (!out_valid_q || m_tready);

	bur_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.item         (back_entry),
		.total_length (total_length_q),
		.expected_crc (expected_crc_q),
		.base_address (base_address_q),
		.result_q     (result_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = result_q.reply_kind;
	assign m_tdata  = {result_q.running_crc, result_q.err_status, result_q.session_state,
	                   result_q.write_byte, result_q.write_address, result_q.write_valid,
	                   result_q.reply_length, result_q.reply_offset, result_q.reply_code,
	                   result_q.consumed};

	// A storage write only happens for a byte that belongs to the session.
	a_write_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[57] |-> m_tdata[0])
		else $error("write without consumed");

	// After a write the session must still be receiving.
	a_write_receiving: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[57] |-> m_tdata[100:98] == PH_RECEIVING)
		else $error("write outside receiving");

	// A nack always leaves the session in the error state.
	a_nack_error: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == RK_NACK |-> m_tdata[100:98] == PH_ERROR)
		else $error("nack without error state");

	// The back only takes an item that the queue holds.
	a_take_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> q_not_empty)
		else $error("take from empty queue");
endmodule

[tb/bur_checker.sv]
// Checker for the block upload receiver: follows both streams and the register port and compares.
`timescale 1ns / 100ps
module bur_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic [2:0]   s_tuser,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [135:0] m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           mismatches,
	output int           pending,
	output int           results_seen,
	output logic [31:0]  session_crc
);
	import bur_pkg::*;

	// Register copies.
	logic [31:0] cfg_total, cfg_crc, cfg_base;
	logic [7:0]  cfg_handle;

	// Session state as the block should hold it.
	phase_t      st_phase;
	err_t        st_err;
	logic [31:0] st_crc, st_next, st_cstart;
	logic [15:0] st_csize, st_ccount;
	logic        st_copen;

	result_t     replies_due[$];

	assign session_crc = st_crc;

	function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] d);
		logic [31:0] r;
		r = ~acc ^ {24'd0, d};
		for (int i = 0; i < 8; i++)
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return ~r;
	endfunction

	task automatic set_error(input err_t e);
		st_err = e;
		st_phase = PH_ERROR;
		st_copen = 1'b0;
	endtask

	// Works out the result of one accepted item and advances the session state.
	task automatic predict_reply(input mode_t md, input logic [111:0] d, input logic last);
		result_t     r;
		logic [7:0]  hnd;
		logic [31:0] off, hcrc;
		logic [15:0] dlen;
		logic [7:0]  dbyte, reason;
		logic        sok, host_ok;
		hnd    = d[7:0];
		off    = d[39:8];
		dlen   = d[55:40];
		dbyte  = d[63:56];
		sok    = d[64];
		hcrc   = d[96:65];
		reason = d[104:97];
		r = '0;
		host_ok = (st_phase == PH_RECEIVING) && (hnd == cfg_handle);
		case (md)
			MODE_START: begin
				if (cfg_total == 0 || cfg_handle == 0) set_error(ERR_PARAM);
				else if (st_phase == PH_RECEIVING) set_error(ERR_BUSY);
				else if (!sok) set_error(ERR_STORAGE);
				else begin
					st_phase = PH_RECEIVING;
					st_err = ERR_OK;
					st_next = '0;
					st_crc = '0;
					st_copen = 1'b0;
					st_cstart = '0;
					st_csize = '0;
					st_ccount = '0;
				end
			end
			MODE_BEGIN: if (host_ok) begin
				r.consumed = 1'b1;
				r.reply_kind = RK_ACK;
				r.reply_length = dlen;
			end
			MODE_HABORT: if (host_ok) begin
				r.consumed = 1'b1;
				st_phase = PH_ABORTED;
				st_err = ERR_OK;
				st_copen = 1'b0;
				r.reply_kind = RK_ACK;
				r.reply_offset = off;
				r.reply_length = dlen;
			end
			MODE_HEADER: if (host_ok) begin
				r.consumed = 1'b1;
				st_copen = 1'b0;
				if (off != st_next) begin
					r.reply_kind = RK_NACK;
					r.reply_code = NACK_OFFSET;
					r.reply_offset = off;
					set_error(ERR_OFFSET);
				end else if ({1'b0, off} + {17'd0, dlen} > {1'b0, cfg_total}) begin
					r.reply_kind = RK_NACK;
					r.reply_code = NACK_PARAM;
					r.reply_offset = off;
					set_error(ERR_PARAM);
				end else if (!sok) begin
					r.reply_kind = RK_NACK;
					r.reply_code = NACK_STORAGE;
					r.reply_offset = off;
					set_error(ERR_STORAGE);
				end else if (dlen == 0) begin
					r.reply_kind = RK_ACK;
					r.reply_offset = off;
				end else begin
					st_copen = 1'b1;
					st_cstart = off;
					st_csize = dlen;
					st_ccount = '0;
				end
			end
			MODE_BYTE: if (st_phase == PH_RECEIVING && st_copen) begin
				r.consumed = 1'b1;
				r.write_valid = 1'b1;
				r.write_byte = dbyte;
				r.write_address = cfg_base + st_cstart + {16'd0, st_ccount};
				st_crc = crc32_step(st_crc, dbyte);
				st_next = st_next + 32'd1;
				st_ccount = st_ccount + 16'd1;
				if (st_ccount >= st_csize || last) begin
					st_copen = 1'b0;
					r.reply_kind = RK_ACK;
					r.reply_offset = st_cstart;
					r.reply_length = st_ccount;
				end
			end
			MODE_END: if (host_ok) begin
				r.consumed = 1'b1;
				st_copen = 1'b0;
				r.reply_offset = off;
				if (st_next != cfg_total || (cfg_crc != 0 && st_crc != cfg_crc) ||
						(hcrc != 0 && hcrc != st_crc)) begin
					r.reply_kind = RK_NACK;
					r.reply_code = NACK_VERIFY;
					set_error(ERR_VERIFY);
				end else begin
					st_phase = PH_COMPLETED;
					st_err = ERR_OK;
					r.reply_kind = RK_ACK;
					r.reply_length = dlen;
				end
			end
			MODE_LABORT: begin
				if (st_phase == PH_RECEIVING) begin
					r.reply_kind = RK_ABORT;
					r.reply_code = reason;
				end
				st_phase = PH_ABORTED;
				st_err = ERR_OK;
				st_copen = 1'b0;
			end
			default: ;
		endcase
		r.session_state = st_phase;
		r.err_status = st_err;
		r.running_crc = st_crc;
		replies_due.push_back(r);
	endtask

	task automatic check_field(input string nm, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			if (mismatches < 10)
				$display("%0t: result %0d field %s expected %h got %h",
					$realtime, results_seen, nm, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cfg_total <= '0;
			cfg_crc <= '0;
			cfg_base <= '0;
			cfg_handle <= '0;
			st_phase = PH_IDLE;
			st_err = ERR_OK;
			st_crc = '0;
			st_next = '0;
			st_cstart = '0;
			st_csize = '0;
			st_ccount = '0;
			st_copen = 1'b0;
			mismatches = 0;
			results_seen = 0;
			replies_due.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					REG_TOTAL_LENGTH: cfg_total <= pwdata;
					REG_EXPECTED_CRC: cfg_crc <= pwdata;
					REG_HANDLE:       cfg_handle <= pwdata[7:0];
					REG_BASE_ADDRESS: cfg_base <= pwdata;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (replies_due.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with nothing expected, data %h", $realtime, m_tdata);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					check_field("consumed", 32'(want.consumed), 32'(m_tdata[0]));
					check_field("reply_kind", 32'(want.reply_kind), 32'(m_tuser));
					check_field("reply_code", 32'(want.reply_code), 32'(m_tdata[8:1]));
					check_field("reply_offset", want.reply_offset, m_tdata[40:9]);
					check_field("reply_length", 32'(want.reply_length), 32'(m_tdata[56:41]));
					check_field("write_valid", 32'(want.write_valid), 32'(m_tdata[57]));
					check_field("write_address", want.write_address, m_tdata[89:58]);
					check_field("write_byte", 32'(want.write_byte), 32'(m_tdata[97:90]));
					check_field("session_state", 32'(want.session_state),
						32'(m_tdata[100:98]));
					check_field("err_status", 32'(want.err_status), 32'(m_tdata[103:101]));
					check_field("running_crc", want.running_crc, m_tdata[135:104]);
				end
				results_seen++;
			end
			if (s_tvalid && s_tready)
				predict_reply(mode_t'(s_tuser), s_tdata, s_tlast);
			pending = replies_due.size();
		end
	end

endmodule

[tb/block_upload_receiver_tb.sv]
// Testbench top for the block upload receiver: stimulus, pacing, watchdog and verdict.
`timescale 1ns / 100ps
module block_upload_receiver_tb;
	import bur_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;   // handle, offset, pay_len, data_byte, storage_ok, end_crc,
	                              // abort_reason, zero fill
	logic [2:0]   s_tuser = '0;   // mode
	logic         s_tlast = 1'b0; // data_last
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;        // consumed, reply_code, reply_offset, reply_length,
	                              // write_valid, write_address, write_byte, session_state,
	                              // err_status, running_crc
	logic [1:0]   m_tuser;        // reply_kind
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	int           mismatches, pending, results_seen;
	logic [31:0]  session_crc;

	// Pacing controls shared by the sender and the receiver.
	bit           no_gaps = 1'b0;
	bit           hold_request = 1'b0;
	int           items_sent = 0;
	int           sessions = 0;
	int           quiet_cycles = 0;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	always #2 clk = ~clk;

	block_upload_receiver u_top (.*);

	bur_checker u_checker (.*);

	// The watchdog counts cycles without any accepted item on either stream and without a register access.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: nothing moved for %0d cycles, %0d results waiting",
				QUIET_LIMIT, pending);
			$display("** block_upload_receiver: FAILED **");
			$finish;
		end
	end

	// The receiver draws a stall before each result; on request it holds off for a long
	// stretch so that the internal queue fills and the input side stalls.
	initial begin
		int stall;
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			stall = no_gaps ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(negedge clk);
			while (!m_tvalid) @(negedge clk);
			@(posedge clk);
		end
	end

	task automatic reg_write(input logic [3:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until every predicted result has arrived, then lets the pipeline settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] total, input logic [31:0] crc,
			input logic [7:0] hnd, input logic [31:0] base);
		drain();
		reg_write(REG_TOTAL_LENGTH, total);
		reg_write(REG_EXPECTED_CRC, crc);
		reg_write(REG_HANDLE, {24'd0, hnd});
		reg_write(REG_BASE_ADDRESS, base);
	endtask

	// Offers one item after a random gap and returns at the edge where it is taken.
	task automatic send_item(input mode_t md, input logic [7:0] hnd, input logic [31:0] off,
			input logic [15:0] dlen, input logic [7:0] dbyte, input logic dlast,
			input logic sok, input logic [31:0] hcrc, input logic [7:0] reason);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= md;
		s_tlast <= dlast;
		s_tdata <= {7'd0, reason, hcrc, sok, dbyte, dlen, off, hnd};
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic send_simple(input mode_t md, input logic [7:0] hnd, input logic [31:0] off,
			input logic [15:0] dlen, input logic sok);
		send_item(md, hnd, off, dlen, 8'($urandom), 1'($urandom_range(0, 1)), sok, 32'd0,
			8'($urandom));
	endtask

	task automatic send_noise();
		send_item(mode_t'($urandom_range(0, 7)), 8'($urandom), $urandom, 16'($urandom),
			8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
			8'($urandom));
	endtask

	task automatic send_bytes(input int count, input bit end_early);
		for (int i = 0; i < count; i++)
			send_item(MODE_BYTE, 8'($urandom), $urandom, 16'($urandom), 8'($urandom),
				end_early && i == count - 1, 1'($urandom), $urandom, 8'($urandom));
	endtask

	// One upload session: mostly well-formed chunk sequences with random content, with
	// foreign packets, broken headers and aborts mixed in now and then.
	task automatic run_session();
		logic [31:0] total, base, next, crc_cfg, end_crc;
		logic [7:0]  hnd;
		int          len, sent, pick;
		total = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 40);
		hnd = 8'($urandom_range(1, 255));
		base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 : $urandom;
		configure(total, 32'd0, hnd, base);
		sessions++;
		send_item(MODE_START, 8'($urandom), $urandom, 16'($urandom), 8'($urandom),
			1'($urandom_range(0, 1)), $urandom_range(0, 15) != 0, $urandom, 8'($urandom));
		if ($urandom_range(0, 1)) send_simple(MODE_BEGIN, hnd, $urandom, 16'($urandom), 1'b1);
		next = '0;
		while (next < total) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_noise();
				continue;
			end
			if (pick < 9) begin
				send_simple(mode_t'($urandom_range(1, 5)), hnd ^ 8'($urandom_range(1, 255)),
					$urandom, 16'($urandom), 1'b1);
				continue;
			end
			if (pick < 11) begin
				send_simple(MODE_HEADER, hnd, next + 32'($urandom_range(1, 3)), 16'd4, 1'b1);
				break;
			end
			if (pick < 12) begin
				send_simple(MODE_HEADER, hnd, next, 16'(total - next + 1), 1'b1);
				break;
			end
			if (pick < 13) begin
				send_simple(MODE_HEADER, hnd, next, 16'd1, 1'b0);
				break;
			end
			if (pick < 14) begin
				send_simple(MODE_HABORT, hnd, $urandom, 16'($urandom), 1'b1);
				return;
			end
			if (pick < 15) begin
				send_item(MODE_LABORT, 8'($urandom), $urandom, 16'($urandom), 8'($urandom),
					1'b0, 1'b1, $urandom, 8'($urandom));
				return;
			end
			if (pick < 17) begin
				send_simple(MODE_HEADER, hnd, next, 16'd0, 1'b1);
				continue;
			end
			len = $urandom_range(1, (total - next > 12) ? 12 : total - next);
			send_simple(MODE_HEADER, hnd, next, 16'(len), 1'b1);
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// A new header drops the chunk before all of its bytes have been sent.
				sent = $urandom_range(0, len - 1);
				send_bytes(sent, 1'b0);
				next = next + 32'(sent);
				continue;
			end
			sent = (pick == 1) ? $urandom_range(1, len) : len;
			send_bytes(sent, pick == 1);
			next = next + 32'(sent);
			// Stray bytes after the chunk has closed are ignored.
			if ($urandom_range(0, 9) == 0) send_bytes(1, 1'b0);
		end
		// The expected CRC is taken from the session once all bytes have been checked.
		drain();
		pick = $urandom_range(0, 9);
		crc_cfg = (pick < 4) ? session_crc : (pick == 4) ? session_crc ^ 32'h1 : 32'd0;
		reg_write(REG_EXPECTED_CRC, crc_cfg);
		pick = $urandom_range(0, 9);
		end_crc = (pick < 5) ? session_crc : (pick == 5) ? $urandom : 32'd0;
		send_item(MODE_END, hnd, $urandom, 16'($urandom), 8'($urandom), 1'b0, 1'b1, end_crc,
			8'($urandom));
		if ($urandom_range(0, 3) == 0) send_noise();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: invalid parameters at start, then a real session with each case.
		send_item(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1,
			32'hFFFF_FFFF, 8'hFF);
		send_simple(MODE_START, 8'h00, 32'd0, 16'd0, 1'b1);
		send_item(MODE_LABORT, 8'd0, 32'd0, 16'd0, 8'd0, 1'b0, 1'b0, 32'd0, 8'hA5);
		configure(32'd8, 32'd0, 8'hFF, 32'hFFFF_FFFC);
		send_simple(MODE_START, 8'h00, 32'd0, 16'd0, 1'b0);
		send_simple(MODE_START, 8'h00, 32'd0, 16'd0, 1'b1);
		send_simple(MODE_START, 8'h00, 32'd0, 16'd0, 1'b1);
		send_simple(MODE_START, 8'h00, 32'd0, 16'd0, 1'b1);
		send_simple(MODE_BEGIN, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
		send_simple(MODE_BEGIN, 8'h7F, 32'd0, 16'h1234, 1'b1);
		send_bytes(1, 1'b0);
		send_simple(MODE_HEADER, 8'hFF, 32'd0, 16'd0, 1'b1);
		send_simple(MODE_HEADER, 8'hFF, 32'd0, 16'd3, 1'b1);
		send_simple(MODE_HEADER, 8'hFF, 32'd0, 16'd5, 1'b1);
		send_item(MODE_BYTE, 8'd0, 32'd0, 16'd0, 8'h00, 1'b0, 1'b0, 32'd0, 8'd0);
		send_item(MODE_BYTE, 8'd0, 32'd0, 16'd0, 8'hFF, 1'b1, 1'b0, 32'd0, 8'd0);
		send_simple(MODE_HEADER, 8'hFF, 32'd2, 16'd6, 1'b1);
		send_bytes(6, 1'b0);
		send_simple(MODE_END, 8'hFF, 32'h55, 16'h9, 1'b1);
		send_item(MODE_LABORT, 8'd0, 32'd0, 16'd0, 8'd0, 1'b0, 1'b0, 32'd0, 8'h3C);
		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h01, 32'd0);
		send_simple(MODE_START, 8'h00, 32'd0, 16'd0, 1'b1);
		send_simple(MODE_HEADER, 8'h01, 32'd4, 16'd1, 1'b1);
		send_simple(MODE_START, 8'h00, 32'd0, 16'd0, 1'b1);
		send_simple(MODE_HEADER, 8'h01, 32'd0, 16'hFFFF, 1'b0);
		send_simple(MODE_START, 8'h00, 32'd0, 16'd0, 1'b1);
		send_simple(MODE_HABORT, 8'h01, 32'hDEAD_BEEF, 16'hFFFF, 1'b1);
		configure(32'd2, 32'd0, 8'h01, 32'd0);
		send_simple(MODE_START, 8'h00, 32'd0, 16'd0, 1'b1);
		send_simple(MODE_HEADER, 8'h01, 32'd0, 16'd3, 1'b1);

		// Random sessions with noise between them; a long receiver hold and a stretch
		// without gaps fall somewhere in the run.
		while (items_sent < 1350) begin
			if (sessions == 10) hold_request = 1'b1;
			no_gaps = (sessions % 9) == 4;
			if ($urandom_range(0, 4) == 0) begin
				for (int i = 0; i < 5; i++) send_noise();
			end
			run_session();
		end
		no_gaps = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		$display("Covered %0d input items in %0d upload sessions, %0d results checked.",
			items_sent, sessions, results_seen);
		if (mismatches == 0 && pending == 0)
			$display("** block_upload_receiver: PASSED **");
		else
			$display("** block_upload_receiver: FAILED **");
		$finish;
	end

endmodule

[files.f]
sv/bur_pkg.sv
sv/bur_front.sv
sv/bur_queue.sv
sv/bur_back.sv
sv/block_upload_receiver.sv
tb/bur_checker.sv
tb/block_upload_receiver_tb.sv
